>>> rtl/bfie_pkg.sv
`default_nettype none

package bfie_pkg;

  localparam int BIT_NUM_W  = 9;   // bit number of a field bound
  localparam int BYTE_IDX_W = 6;   // byte index reachable from a bit number
  localparam int BYTE_W     = 8;
  localparam int VALUE_W    = 32;
  localparam int USED_W     = 7;
  localparam int LEN_W      = 10;  // field length, up to 512
  localparam int CNT_W      = 7;   // bytes touched by one field, up to 64
  localparam int SHIFT_W    = 3;
  localparam int STORE_LIMIT = 1 << BYTE_IDX_W;
  localparam logic [USED_W-1:0] USED_RESET = 7'd64;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_TOO_WIDE = 2'd2,
    ST_BOUNDS   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FETCH,
    S_LOOP,
    S_FINISH
  } state_t;

  // what the bounds checker hands to the sequencer
  typedef struct packed {
    status_t                 status;
    logic [BYTE_IDX_W-1:0]   first_byte;
    logic [BYTE_IDX_W-1:0]   last_byte;
    logic [SHIFT_W-1:0]      tail_shift;
    logic [CNT_W-1:0]        byte_count;
  } chk_t;

endpackage

`default_nettype wire

>>> rtl/bfie_if.sv
`default_nettype none

interface bfie_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          kind;
  logic [bfie_pkg::BIT_NUM_W-1:0]      first_bit;
  logic [bfie_pkg::BIT_NUM_W-1:0]      last_bit;
  logic [bfie_pkg::VALUE_W-1:0]        write_value;

  modport source (output valid, kind, first_bit, last_bit, write_value, input ready);
  modport sink   (input valid, kind, first_bit, last_bit, write_value, output ready);
endinterface

interface bfie_out_if;
  logic                                valid;
  logic                                ready;
  logic [bfie_pkg::VALUE_W-1:0]        read_value;
  logic [1:0]                          status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

`default_nettype wire

>>> rtl/bfie_ram.sv
`default_nettype none

module bfie_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/bfie_check.sv
`default_nettype none

module bfie_check #(
  parameter int BUFFER_BYTES   = 64,
  parameter int MAX_FIELD_BITS = 32,
  parameter int WIDE_W         = 40
) (
  input  wire bfie_pkg::kind_t                  kind,
  input  wire logic [bfie_pkg::BIT_NUM_W-1:0]   first_bit,
  input  wire logic [bfie_pkg::BIT_NUM_W-1:0]   last_bit,
  input  wire logic [bfie_pkg::VALUE_W-1:0]     write_value,
  input  wire logic [bfie_pkg::USED_W-1:0]      used_bytes,
  output bfie_pkg::chk_t                        chk,
  output logic      [WIDE_W-1:0]                aligned_value,
  output logic      [WIDE_W-1:0]                field_mask
);

  localparam int CapW = ($clog2(BUFFER_BYTES + 1) > bfie_pkg::USED_W) ?
                        $clog2(BUFFER_BYTES + 1) : bfie_pkg::USED_W;

  logic [CapW-1:0]                        used_cap;
  logic [bfie_pkg::LEN_W-1:0]             len;
  logic [bfie_pkg::VALUE_W-1:0]           value_keep;
  logic [WIDE_W-1:0]                      len_mask;
  logic [WIDE_W+bfie_pkg::VALUE_W-1:0]    value_ext;
  logic                                   reversed;
  logic                                   beyond;
  logic                                   too_long;
  logic                                   too_wide;

  always_comb begin
    used_cap = (CapW'(used_bytes) > CapW'(BUFFER_BYTES)) ? CapW'(BUFFER_BYTES)
                                                          : CapW'(used_bytes);
    chk.first_byte = first_bit[bfie_pkg::BIT_NUM_W-1:bfie_pkg::SHIFT_W];
    chk.last_byte  = last_bit[bfie_pkg::BIT_NUM_W-1:bfie_pkg::SHIFT_W];
    chk.tail_shift = ~last_bit[bfie_pkg::SHIFT_W-1:0];
    chk.byte_count = {1'b0, chk.last_byte} - {1'b0, chk.first_byte} + 1'b1;

    reversed = last_bit < first_bit;
    beyond   = CapW'(chk.last_byte) >= used_cap;
    len      = {1'b0, last_bit} - {1'b0, first_bit} + 1'b1;
    too_long = len > bfie_pkg::LEN_W'(MAX_FIELD_BITS);

    // thermometer masks: bit i set while i is below the field length
    for (int i = 0; i < bfie_pkg::VALUE_W; i++) begin
      value_keep[i] = bfie_pkg::LEN_W'(i) < len;
    end
    for (int i = 0; i < WIDE_W; i++) begin
      len_mask[i] = bfie_pkg::LEN_W'(i) < len;
    end
    too_wide = (kind == bfie_pkg::KIND_WRITE) && (|(write_value & ~value_keep));

    if (reversed || beyond) begin
      chk.status = bfie_pkg::ST_BOUNDS;
    end else if (too_long) begin
      chk.status = bfie_pkg::ST_TOO_LONG;
    end else if (too_wide) begin
      chk.status = bfie_pkg::ST_TOO_WIDE;
    end else begin
      chk.status = bfie_pkg::ST_OK;
    end

    // value lsb goes to the bit position of last_bit inside its byte
    value_ext     = {{WIDE_W{1'b0}}, write_value};
    aligned_value = value_ext[WIDE_W-1:0] << chk.tail_shift;
    field_mask    = len_mask << chk.tail_shift;
  end

endmodule

`default_nettype wire

>>> rtl/bit_field_buffer_insert_extract.sv
`default_nettype none

// Bit-addressed packet buffer with field insert and extract. Bit 0 is the msb
// of byte 0. Each input beat is a write (insert write_value, lsb at last_bit),
// a read (return first_bit..last_bit right-aligned) or a clear (zero the bytes
// in use); every beat gives exactly one result beat with a status. The buffer
// lives in a byte-wide ram with one read and one write port plus a valid bit
// per byte, so reset and clear take effect at once and need no sweep.
// A beat is taken only in the idle state. Clear, the unused kind and any
// failed check go from the check state straight to finish; a good write or
// read passes a fetch state and then loops over the n bytes the field touches
// (1 to 5 for a field of up to 32 bits), as one byte merge/shift unit walks
// the field one ram byte per cycle (read of the next byte overlaps the write
// of the current one). The result sits in an output register, so a new beat
// can be taken while the previous result waits to be drained.
module bit_field_buffer_insert_extract #(
  parameter int BUFFER_BYTES   = 64,
  parameter int MAX_FIELD_BITS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  bfie_in_if.sink                               in_if,
  bfie_out_if.source                            out_if,
  input  wire logic                             cfg_wr_en,
  input  wire logic [bfie_pkg::USED_W-1:0]      cfg_wr_data
);

  // only the first 64 bytes are reachable from a 9-bit bit number
  localparam int StoreDepth = (BUFFER_BYTES < bfie_pkg::STORE_LIMIT) ?
                              BUFFER_BYTES : bfie_pkg::STORE_LIMIT;
  localparam int AddrW = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int WideW = MAX_FIELD_BITS + bfie_pkg::BYTE_W;

  // sequencer
  bfie_pkg::state_t state_r, state_nxt;

  // captured beat
  bfie_pkg::kind_t                      kind_r;
  logic [bfie_pkg::BIT_NUM_W-1:0]       first_r;
  logic [bfie_pkg::BIT_NUM_W-1:0]       last_r;
  logic [bfie_pkg::VALUE_W-1:0]         value_r;

  // config
  logic [bfie_pkg::USED_W-1:0]          used_bytes_r;

  // check results
  bfie_pkg::chk_t                       chk;
  logic [WideW-1:0]                     chk_aligned;
  logic [WideW-1:0]                     chk_mask;
  bfie_pkg::status_t                    status_r;
  logic [bfie_pkg::SHIFT_W-1:0]         tail_r;
  logic                                 field_op;

  // byte walk
  logic [WideW-1:0]                     aligned_r;
  logic [WideW-1:0]                     mask_r;
  logic [WideW-1:0]                     acc_r;
  logic [AddrW-1:0]                     rd_addr_r;
  logic [AddrW-1:0]                     data_addr_r;
  logic [bfie_pkg::CNT_W-1:0]           left_r;
  logic                                 hit_r;
  logic                                 hit_nxt;
  logic [StoreDepth-1:0]                valid_r;

  // ram
  logic                                 ram_we;
  logic [bfie_pkg::BYTE_W-1:0]          ram_rd_data;
  logic [bfie_pkg::BYTE_W-1:0]          cur_byte;
  logic [bfie_pkg::BYTE_W-1:0]          merged_byte;

  // result
  logic                                 out_valid_r;
  logic [bfie_pkg::VALUE_W-1:0]         out_value_r;
  bfie_pkg::status_t                    out_status_r;
  logic                                 out_load;
  logic [WideW-1:0]                     field_bits;
  logic [WideW+bfie_pkg::VALUE_W-1:0]   field_ext;
  logic [bfie_pkg::VALUE_W-1:0]         result_value;

  bfie_check #(
    .BUFFER_BYTES   (BUFFER_BYTES),
    .MAX_FIELD_BITS (MAX_FIELD_BITS),
    .WIDE_W         (WideW)
  ) u_check (
    .kind          (kind_r),
    .first_bit     (first_r),
    .last_bit      (last_r),
    .write_value   (value_r),
    .used_bytes    (used_bytes_r),
    .chk           (chk),
    .aligned_value (chk_aligned),
    .field_mask    (chk_mask)
  );

  bfie_ram #(
    .WIDTH (bfie_pkg::BYTE_W),
    .DEPTH (StoreDepth)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (data_addr_r),
    .wr_data (merged_byte),
    .rd_addr (rd_addr_r),
    .rd_data (ram_rd_data)
  );

  assign field_op = (kind_r == bfie_pkg::KIND_WRITE) || (kind_r == bfie_pkg::KIND_READ);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfie_pkg::S_IDLE: begin
        if (in_if.valid) begin
          state_nxt = bfie_pkg::S_CHECK;
        end
      end
      bfie_pkg::S_CHECK: begin
        if (field_op && (chk.status == bfie_pkg::ST_OK)) begin
          state_nxt = bfie_pkg::S_FETCH;
        end else begin
          state_nxt = bfie_pkg::S_FINISH;
        end
      end
      bfie_pkg::S_FETCH: begin
        state_nxt = bfie_pkg::S_LOOP;
      end
      bfie_pkg::S_LOOP: begin
        if (left_r == bfie_pkg::CNT_W'(1)) begin
          state_nxt = bfie_pkg::S_FINISH;
        end
      end
      bfie_pkg::S_FINISH: begin
        if (!out_valid_r || out_if.ready) begin
          state_nxt = bfie_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bfie_pkg::S_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_if.ready = (state_r == bfie_pkg::S_IDLE);
    ram_we      = (state_r == bfie_pkg::S_LOOP) && (kind_r == bfie_pkg::KIND_WRITE);
    out_load    = (state_r == bfie_pkg::S_FINISH) && (!out_valid_r || out_if.ready);
  end

  // shared byte unit: a never-written byte reads as zero
  always_comb begin
    cur_byte    = hit_r ? ram_rd_data : '0;
    merged_byte = (cur_byte & ~mask_r[bfie_pkg::BYTE_W-1:0]) |
                  (aligned_r[bfie_pkg::BYTE_W-1:0] & mask_r[bfie_pkg::BYTE_W-1:0]);
    hit_nxt     = (32'(rd_addr_r) < 32'(StoreDepth)) ? valid_r[rd_addr_r] : 1'b0;
  end

  // right-align the gathered field
  always_comb begin
    field_bits = (acc_r & mask_r) >> tail_r;
    field_ext  = {{bfie_pkg::VALUE_W{1'b0}}, field_bits};
    if ((kind_r == bfie_pkg::KIND_READ) && (status_r == bfie_pkg::ST_OK)) begin
      result_value = field_ext[bfie_pkg::VALUE_W-1:0];
    end else begin
      result_value = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bfie_pkg::S_IDLE;
      used_bytes_r <= bfie_pkg::USED_RESET;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        used_bytes_r <= cfg_wr_data;
      end
      // clear drops the valid bits of the bytes in use
      if ((state_r == bfie_pkg::S_CHECK) && (kind_r == bfie_pkg::KIND_CLEAR)) begin
        for (int i = 0; i < StoreDepth; i++) begin
          if (bfie_pkg::USED_W'(i) < used_bytes_r) begin
            valid_r[i] <= 1'b0;
          end
        end
      end
      if (ram_we) begin
        valid_r[data_addr_r] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      kind_r  <= bfie_pkg::kind_t'(in_if.kind);
      first_r <= in_if.first_bit;
      last_r  <= in_if.last_bit;
      value_r <= in_if.write_value;
    end

    unique case (state_r)
      bfie_pkg::S_CHECK: begin
        status_r  <= field_op ? chk.status : bfie_pkg::ST_OK;
        tail_r    <= chk.tail_shift;
        aligned_r <= chk_aligned;
        mask_r    <= chk_mask;
        acc_r     <= '0;
        left_r    <= chk.byte_count;
        // writes walk from the last byte down, reads from the first byte up
        if (kind_r == bfie_pkg::KIND_WRITE) begin
          rd_addr_r <= chk.last_byte[AddrW-1:0];
        end else begin
          rd_addr_r <= chk.first_byte[AddrW-1:0];
        end
      end
      bfie_pkg::S_FETCH, bfie_pkg::S_LOOP: begin
        data_addr_r <= rd_addr_r;
        hit_r       <= hit_nxt;
        if (kind_r == bfie_pkg::KIND_WRITE) begin
          rd_addr_r <= rd_addr_r - 1'b1;
        end else begin
          rd_addr_r <= rd_addr_r + 1'b1;
        end
        if (state_r == bfie_pkg::S_LOOP) begin
          left_r <= left_r - 1'b1;
          if (kind_r == bfie_pkg::KIND_WRITE) begin
            aligned_r <= aligned_r >> bfie_pkg::BYTE_W;
            mask_r    <= mask_r >> bfie_pkg::BYTE_W;
          end else begin
            acc_r <= {acc_r[WideW-bfie_pkg::BYTE_W-1:0], cur_byte};
          end
        end
      end
      default: begin
      end
    endcase

    if (out_load) begin
      out_value_r  <= result_value;
      out_status_r <= status_r;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.read_value = out_value_r;
  assign out_if.status     = out_status_r;

endmodule

`default_nettype wire

>>> tb/tb_bit_field_buffer_insert_extract.sv
`default_nettype none

module tb_bit_field_buffer_insert_extract;
  import bfie_pkg::*;

  // block geometry as instantiated below
  localparam int STORE_BYTES   = 64;
  localparam int MAX_FIELD     = 32;
  localparam logic [1:0] KIND_SPARE = 2'd3;   // unused opcode, answers ok with no effect

  // timing knobs
  localparam int SETTLE_CYCLES  = 12;    // longer than a five-byte field walk
  localparam int HOLD_CYCLES    = 200;   // receiver back-pressure burst
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake or register write at all
  localparam int SEG_BEATS      = 108;

  // random segments: buffer size and idle percentages for sender and receiver
  localparam int SEG_USED [6]      = '{37, 1, 64, 5, 64, 23};
  localparam int SEG_SEND_IDLE [6] = '{9, 9, 66, 66, 0, 0};
  localparam int SEG_RECV_IDLE [6] = '{66, 66, 9, 9, 0, 0};
  localparam int HOLD_SEG          = 4;

  typedef struct packed {
    logic [1:0]           kind;
    logic [BIT_NUM_W-1:0] first_bit;
    logic [BIT_NUM_W-1:0] last_bit;
    logic [VALUE_W-1:0]   write_value;
  } field_op_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    status_t            status;
  } field_result_t;

  // per-beat note: take the hand-written result instead of the predicted one
  typedef struct packed {
    logic          by_hand;
    field_result_t want;
  } hand_note_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [1:0]           kind;
    logic [BIT_NUM_W-1:0] first_bit;
    logic [BIT_NUM_W-1:0] last_bit;
    logic [VALUE_W-1:0]   value;      // write_value, or used_bytes on a config row
    logic                 by_hand;
    logic [VALUE_W-1:0]   exp_read;
    status_t              exp_status;
  } directed_row_t;

  localparam logic ROW_CFG   = 1'b1;
  localparam logic ROW_BEAT  = 1'b0;
  localparam logic HAND      = 1'b1;
  localparam logic PREDICTED = 1'b0;

  // directed sweep: full-width fields, buffer ends, byte-straddling fields,
  // every error code, bounds winning over length, clear limited to the bytes in use
  localparam directed_row_t DIRECTED_ROWS [27] = '{
    '{ROW_CFG,  KIND_WRITE, 9'd0,   9'd0,   32'd64,        PREDICTED, 32'h0,        ST_OK},
    '{ROW_BEAT, KIND_READ,  9'd0,   9'd31,  32'h0,         HAND,      32'h0,        ST_OK},
    '{ROW_BEAT, KIND_WRITE, 9'd0,   9'd31,  32'hffff_ffff, HAND,      32'h0,        ST_OK},
    '{ROW_BEAT, KIND_READ,  9'd0,   9'd31,  32'h0,         HAND,      32'hffff_ffff, ST_OK},
    '{ROW_BEAT, KIND_WRITE, 9'd3,   9'd12,  32'h2a5,       PREDICTED, 32'h0,        ST_OK},
    '{ROW_BEAT, KIND_READ,  9'd0,   9'd15,  32'h0,         PREDICTED, 32'h0,        ST_OK},
    '{ROW_BEAT, KIND_WRITE, 9'd480, 9'd511, 32'h1234_5678, HAND,      32'h0,        ST_OK},
    '{ROW_BEAT, KIND_READ,  9'd480, 9'd511, 32'h0,         HAND,      32'h1234_5678, ST_OK},
    '{ROW_BEAT, KIND_WRITE, 9'd100, 9'd131, 32'hdead_beef, HAND,      32'h0,        ST_OK},
    '{ROW_BEAT, KIND_READ,  9'd100, 9'd131, 32'h0,         HAND,      32'hdead_beef, ST_OK},
    '{ROW_BEAT, KIND_READ,  9'd96,  9'd103, 32'h0,         PREDICTED, 32'h0,        ST_OK},
    '{ROW_BEAT, KIND_WRITE, 9'd5,   9'd5,   32'd2,         HAND,      32'h0,        ST_TOO_WIDE},
    '{ROW_BEAT, KIND_WRITE, 9'd0,   9'd32,  32'h0,         HAND,      32'h0,        ST_TOO_LONG},
    '{ROW_BEAT, KIND_READ,  9'd0,   9'd511, 32'h0,         HAND,      32'h0,        ST_TOO_LONG},
    '{ROW_BEAT, KIND_READ,  9'd10,  9'd9,   32'h0,         HAND,      32'h0,        ST_BOUNDS},
    '{ROW_BEAT, KIND_SPARE, 9'd0,   9'd7,   32'h0,         HAND,      32'h0,        ST_OK},
    '{ROW_CFG,  KIND_WRITE, 9'd0,   9'd0,   32'd1,         PREDICTED, 32'h0,        ST_OK},
    '{ROW_BEAT, KIND_READ,  9'd0,   9'd7,   32'h0,         PREDICTED, 32'h0,        ST_OK},
    '{ROW_BEAT, KIND_READ,  9'd0,   9'd8,   32'h0,         HAND,      32'h0,        ST_BOUNDS},
    '{ROW_BEAT, KIND_WRITE, 9'd0,   9'd40,  32'hffff_ffff, HAND,      32'h0,        ST_BOUNDS},
    '{ROW_BEAT, KIND_WRITE, 9'd6,   9'd7,   32'd3,         HAND,      32'h0,        ST_OK},
    '{ROW_BEAT, KIND_CLEAR, 9'd0,   9'd0,   32'h0,         HAND,      32'h0,        ST_OK},
    '{ROW_CFG,  KIND_WRITE, 9'd0,   9'd0,   32'd64,        PREDICTED, 32'h0,        ST_OK},
    '{ROW_BEAT, KIND_READ,  9'd0,   9'd7,   32'h0,         HAND,      32'h0,        ST_OK},
    '{ROW_BEAT, KIND_READ,  9'd100, 9'd131, 32'h0,         HAND,      32'hdead_beef, ST_OK},
    '{ROW_BEAT, KIND_CLEAR, 9'd0,   9'd0,   32'h0,         HAND,      32'h0,        ST_OK},
    '{ROW_BEAT, KIND_READ,  9'd480, 9'd511, 32'h0,         HAND,      32'h0,        ST_OK}
  };

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [USED_W-1:0] cfg_wr_data;

  bfie_in_if  req_ch ();
  bfie_out_if rsp_ch ();

  bit_field_buffer_insert_extract #(
    .BUFFER_BYTES   (STORE_BYTES),
    .MAX_FIELD_BITS (MAX_FIELD)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (req_ch),
    .out_if      (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // shadow copy of the buffer and the used_bytes register
  logic [BYTE_W-1:0] shadow_bytes [STORE_BYTES];
  logic [USED_W-1:0] shadow_used;

  field_result_t result_q [$];   // results owed by the block, oldest first
  hand_note_t    hand_q [$];     // one note per offered beat, popped at accept

  int error_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_token;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // bit p lives in byte p/8, msb first within the byte
  function automatic field_result_t apply_field_op(field_op_t op);
    field_result_t r;
    int unsigned   in_use;
    int unsigned   len;
    int unsigned   p;
    logic [63:0]   wide;
    r.read_value = '0;
    r.status     = ST_OK;
    in_use = (shadow_used > STORE_BYTES) ? STORE_BYTES : shadow_used;
    wide   = {32'd0, op.write_value};
    if (op.kind == KIND_CLEAR) begin
      for (p = 0; p < in_use; p++) shadow_bytes[p] = '0;
      return r;
    end
    if (op.kind != KIND_WRITE && op.kind != KIND_READ) return r;
    // bounds win over length, length over value width
    if (op.last_bit < op.first_bit || op.last_bit >= in_use * BYTE_W) begin
      r.status = ST_BOUNDS;
    end else begin
      len = op.last_bit - op.first_bit + 1;
      if (len > MAX_FIELD) r.status = ST_TOO_LONG;
      else if (op.kind == KIND_WRITE && (wide >> len) != 0) r.status = ST_TOO_WIDE;
    end
    if (r.status != ST_OK) return r;
    for (p = op.first_bit; p <= op.last_bit; p++) begin
      if (op.kind == KIND_WRITE) begin
        shadow_bytes[p / BYTE_W][BYTE_W - 1 - p % BYTE_W] = wide[op.last_bit - p];
      end else begin
        r.read_value = {r.read_value[VALUE_W-2:0],
                        shadow_bytes[p / BYTE_W][BYTE_W - 1 - p % BYTE_W]};
      end
    end
    return r;
  endfunction

  function automatic void note_failure(string msg);
    error_count++;
    if (error_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // single place where handshakes are observed, so shadow state follows
  // the exact order of accepted beats and register writes
  always @(posedge clk) begin
    field_op_t     op;
    field_result_t got;
    field_result_t want;
    hand_note_t    note;
    if (!rst_n) begin
      foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
      shadow_used = USED_RESET;
    end else begin
      if (cfg_wr_en) shadow_used = cfg_wr_data;
      if (req_ch.valid && req_ch.ready) begin
        op.kind        = req_ch.kind;
        op.first_bit   = req_ch.first_bit;
        op.last_bit    = req_ch.last_bit;
        op.write_value = req_ch.write_value;
        want = apply_field_op(op);
        note = hand_q.pop_front();
        result_q.push_back(note.by_hand ? note.want : want);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.read_value = rsp_ch.read_value;
        got.status     = status_t'(rsp_ch.status);
        if (result_q.size() == 0) begin
          note_failure($sformatf("result beat with nothing outstanding: value %h status %0d",
                                 got.read_value, got.status));
        end else begin
          want = result_q.pop_front();
          if (got.read_value !== want.read_value)
            note_failure($sformatf("read_value mismatch: expected %h got %h",
                                   want.read_value, got.read_value));
          if (got.status !== want.status)
            note_failure($sformatf("status mismatch: expected %0d got %0d",
                                   want.status, got.status));
        end
      end
    end
  end

  // receiver: random ready, plus one long hold-off on request
  initial begin
    int hold_seen;
    hold_seen = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog: any handshake or register write counts as progress
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // returns at the edge where the beat was taken, valid still high
  task automatic offer_beat(input field_op_t op, input logic by_hand,
                            input field_result_t want);
    hand_note_t note;
    note.by_hand = by_hand;
    note.want    = want;
    hand_q.push_back(note);
    req_ch.valid       <= 1'b1;
    req_ch.kind        <= op.kind;
    req_ch.first_bit   <= op.first_bit;
    req_ch.last_bit    <= op.last_bit;
    req_ch.write_value <= op.write_value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // stop sending and let every owed result drain, then let the block settle
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (result_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_used_bytes(input logic [USED_W-1:0] used);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= used;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    directed_row_t row;
    field_op_t     op;
    field_result_t want;
    int unsigned   used_now;
    int unsigned   span;
    int unsigned   len;
    int unsigned   pick;
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    req_ch.valid       = 1'b0;
    req_ch.kind        = KIND_WRITE;
    req_ch.first_bit   = '0;
    req_ch.last_bit    = '0;
    req_ch.write_value = '0;
    error_count        = 0;
    hold_token         = 0;
    send_idle_pct      = SEG_SEND_IDLE[0];
    recv_idle_pct      = SEG_RECV_IDLE[0];
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed sweep
    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      if (row.is_cfg) begin
        write_used_bytes(row.value[USED_W-1:0]);
      end else begin
        op.kind        = row.kind;
        op.first_bit   = row.first_bit;
        op.last_bit    = row.last_bit;
        op.write_value = row.value;
        want.read_value = row.exp_read;
        want.status     = row.exp_status;
        offer_beat(op, row.by_hand, want);
      end
    end

    // random segments; each starts from an idle block with a new buffer size
    want = '0;
    for (int seg = 0; seg < 6; seg++) begin
      send_idle_pct = SEG_SEND_IDLE[seg];
      recv_idle_pct = SEG_RECV_IDLE[seg];
      write_used_bytes(USED_W'(SEG_USED[seg]));
      used_now = SEG_USED[seg];
      span     = used_now * BYTE_W;
      // long receiver stall while the sender keeps pushing
      if (seg == HOLD_SEG) hold_token++;
      for (int n = 0; n < SEG_BEATS; n++) begin
        while ($urandom_range(0, 99) < send_idle_pct) begin
          req_ch.valid <= 1'b0;
          @(posedge clk);
        end
        // mostly in-range fields, full-width ones often
        len = ($urandom_range(0, 3) == 0) ? MAX_FIELD : $urandom_range(1, MAX_FIELD);
        if (len > span) len = span;
        op.first_bit   = BIT_NUM_W'($urandom_range(0, span - len));
        op.last_bit    = BIT_NUM_W'(op.first_bit + len - 1);
        op.write_value = $urandom;
        if (len < VALUE_W) op.write_value &= (32'd1 << len) - 1;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          op.kind = KIND_WRITE;
        end else if (pick < 75) begin
          op.kind = KIND_READ;
        end else if (pick < 80) begin
          op.kind = KIND_CLEAR;
        end else if (pick < 82) begin
          op.kind = KIND_SPARE;
        end else if (pick < 88) begin
          // value too wide for its field, unless the field is full width
          op.kind = KIND_WRITE;
          op.write_value = $urandom;
          if (len < VALUE_W) op.write_value |= 32'd1 << len;
        end else begin
          // unconstrained noise: mostly bound and length errors
          op.kind        = 2'($urandom_range(0, 3));
          op.first_bit   = BIT_NUM_W'($urandom_range(0, (1 << BIT_NUM_W) - 1));
          op.last_bit    = BIT_NUM_W'($urandom_range(0, (1 << BIT_NUM_W) - 1));
          op.write_value = $urandom;
        end
        offer_beat(op, PREDICTED, want);
      end
    end

    wait_drained();
    if (error_count == 0 && result_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (result_q.size() != 0)
        note_failure($sformatf("%0d results never arrived", result_q.size()));
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/bfie_pkg.sv
rtl/bfie_if.sv
rtl/bfie_ram.sv
rtl/bfie_check.sv
rtl/bit_field_buffer_insert_extract.sv
tb/tb_bit_field_buffer_insert_extract.sv
